/* src/tlvbf_pkg.sv */
// ----------------------------------------------------------------------------
// tlvbf_pkg
// Shared constants for the TLV bundle framer: store depth, byte lanes, record codes, ops, status codes.
// ----------------------------------------------------------------------------
package tlvbf_pkg;

    localparam int DEFAULT_BUNDLE_DEPTH = 2048;

    // byte lanes of the bundle store, interleaved on the low address bits
    localparam int LANES     = 4;
    localparam int LANE_BITS = 2;

    localparam logic [7:0] REC_ADDR = 8'h16;
    localparam logic [7:0] REC_END  = 8'h17;

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] STATUS_BUNDLE   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BUSY     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

endpackage

/* src/tlvbf_in_if.sv */
// ----------------------------------------------------------------------------
// tlvbf_in_if
// Input channel: one op and one stream byte per word.
// ----------------------------------------------------------------------------
interface tlvbf_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] in_byte;

    modport source (output valid, output op, output in_byte, input ready);
    modport sink   (input valid, input op, input in_byte, output ready);
endinterface

/* src/tlvbf_out_if.sv */
// ----------------------------------------------------------------------------
// tlvbf_out_if
// Result channel: emitted byte, last flag and status per word.
// ----------------------------------------------------------------------------
interface tlvbf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    logic [1:0] status;

    modport source (output valid, output out_byte, output last, output status, input ready);
    modport sink   (input valid, input out_byte, input last, input status, output ready);
endinterface

/* src/tlvbf_lane_store.sv */
// ----------------------------------------------------------------------------
// tlvbf_lane_store
// Bundle store split into byte lanes; each lane has its own write row, all
// lanes share one read row. Read data is registered.
// ----------------------------------------------------------------------------
module tlvbf_lane_store
    import tlvbf_pkg::*;
#(
    parameter int DEPTH = DEFAULT_BUNDLE_DEPTH,
    localparam int ROWS  = (DEPTH + LANES - 1) / LANES,
    localparam int ROW_W = $clog2(ROWS)
)
(
    input  logic                        clk,
    input  logic [LANES-1:0]            wr_en,
    input  logic [LANES-1:0][ROW_W-1:0] wr_row,
    input  logic [LANES-1:0][7:0]       wr_data,
    input  logic                        rd_en,
    input  logic [ROW_W-1:0]            rd_row,
    output logic [LANES-1:0][7:0]       rd_data
);

    logic [7:0]             mem_reg [LANES][ROWS];
    logic [LANES-1:0][7:0]  rd_data_reg;

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (wr_en[l])
            begin
                mem_reg[l][wr_row[l]] <= wr_data[l];
            end
            if (rd_en)
            begin
                rd_data_reg[l] <= mem_reg[l][rd_row];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/tlv_bundle_framer_with_rebase.sv */
// ----------------------------------------------------------------------------
// tlv_bundle_framer_with_rebase
// TLV record parser that stores a bundle, rebases address records and drains
// the bundle behind a 16-bit length prefix.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready words of {op, in_byte}. op = 0 feeds a stream byte,
//            op = 1 is a drain tick asking for one output byte.
//   result : valid/ready words of {out_byte, last, status}. A stream byte
//            gives no word unless it is refused while a bundle drains
//            (status busy) or dropped because the store is full (overflow).
//            A drain tick gives the prefix low byte, prefix high byte, then
//            the stored bytes; last marks the final one. Ticks with no
//            closed bundle give nothing.
//   base_we/base_wdata : writes the rebase value; write only while idle.
// Throughput: one word per cycle, every item type. The store is four byte
// lanes, so the up-to-four byte write-back of an address record lands in
// the same cycle as its final byte.
// Latency: a result word is valid the cycle after its item is accepted.
// Stall: item.ready follows result.ready while a word is held, so a stalled
// receiver holds the output register and the store read data.
// Reset: parser to type byte, empty bundle, base zero; no clearing pass.
// ----------------------------------------------------------------------------
module tlv_bundle_framer_with_rebase
    import tlvbf_pkg::*;
#(
    parameter int BUNDLE_DEPTH = DEFAULT_BUNDLE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    tlvbf_in_if.sink           item,
    tlvbf_out_if.source        result,
    input  logic               base_we,
    input  logic [31:0]        base_wdata
);

    localparam int ROWS  = (BUNDLE_DEPTH + LANES - 1) / LANES;
    localparam int ROW_W = $clog2(ROWS);
    localparam int WCW   = $clog2(BUNDLE_DEPTH + 1);   // write count, holds depth
    localparam int WCW1  = WCW + 1;
    localparam int IW    = $clog2(BUNDLE_DEPTH + 2);   // positions up to depth+1
    localparam int IW1   = IW + 1;

    typedef enum logic [2:0] {
        PH_TYPE = 3'b001,
        PH_LEN  = 3'b010,
        PH_DATA = 3'b100
    } phase_t;

    // parser and bundle state
    phase_t            phase_reg, phase_next;
    logic [7:0]        rtype_reg, rtype_next;
    logic [8:0]        rem_reg, rem_next;
    logic [31:0]       acc_reg, acc_next;
    logic [IW-1:0]     start_reg, start_next;
    logic [WCW-1:0]    wc_reg, wc_next;
    logic              pending_reg, pending_next;
    logic [IW-1:0]     didx_reg, didx_next;
    logic [31:0]       base_reg;

    // output word
    logic                   res_valid_reg, res_valid_next;
    logic [7:0]             res_byte_reg, res_byte_next;
    logic                   res_last_reg, res_last_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic                   res_mem_reg, res_mem_next;
    logic [LANE_BITS-1:0]   res_lane_reg, res_lane_next;

    // store ports
    logic [LANES-1:0]            wr_en;
    logic [LANES-1:0][ROW_W-1:0] wr_row;
    logic [LANES-1:0][7:0]       wr_data;
    logic                        rd_en;
    logic [ROW_W-1:0]            rd_row;
    logic [LANES-1:0][7:0]       rd_data;

    logic              in_ready;
    logic              in_acc;
    logic [IW-1:0]     wc_ext;
    logic              stored;
    logic [31:0]       acc_shift;
    logic [31:0]       sum;
    logic [8:0]        rem_dec;
    logic              zero_fill;
    logic [15:0]       prefix;
    logic [IW-1:0]     mem_pos;
    logic              drain_last;

    // write-back lanes: lane l takes the byte k places before the field end
    logic [LANE_BITS-1:0] wb_k   [LANES];
    logic [IW-1:0]        wb_pos [LANES];
    logic                 wb_ok  [LANES];
    logic [7:0]           wb_byte[LANES];

    assign in_ready = !res_valid_reg || result.ready;
    assign in_acc   = item.valid && in_ready;
    assign wc_ext   = IW'(wc_reg);
    assign stored   = (wc_reg < WCW'(BUNDLE_DEPTH));
    assign acc_shift = {acc_reg[23:0], item.in_byte};
    assign sum      = acc_shift + base_reg;
    assign rem_dec  = rem_reg - {8'd0, (rem_reg != 9'd0)};
    // address field bytes four or more places before the field end go in as zero;
    // the end is the first position past the store if the field runs past the store
    assign zero_fill = (phase_reg == PH_DATA) && (rtype_reg == REC_ADDR)
                       && (rem_reg >= 9'd5)
                       && (({1'b0, wc_reg} + WCW1'(4)) <= WCW1'(BUNDLE_DEPTH));
    assign prefix     = 16'(wc_reg);
    assign mem_pos    = didx_reg - IW'(2);
    assign drain_last = ({1'b0, didx_reg} >= ({1'b0, wc_ext} + IW1'(1)));

    // field end is the current write position, stored or not
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            wb_k[l]    = wc_ext[LANE_BITS-1:0] - LANE_BITS'(l);
            wb_pos[l]  = wc_ext - IW'(wb_k[l]);
            wb_ok[l]   = ({1'b0, wc_ext} >= ({1'b0, start_reg} + IW1'(wb_k[l])))
                         && ((wb_k[l] != '0) || stored);
            wb_byte[l] = sum[{wb_k[l], 3'b000} +: 8];
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        rtype_next      = rtype_reg;
        rem_next        = rem_reg;
        acc_next        = acc_reg;
        start_next      = start_reg;
        wc_next         = wc_reg;
        pending_next    = pending_reg;
        didx_next       = didx_reg;
        res_valid_next  = res_valid_reg && !result.ready;
        res_byte_next   = res_byte_reg;
        res_last_next   = res_last_reg;
        res_status_next = res_status_reg;
        res_mem_next    = res_mem_reg;
        res_lane_next   = res_lane_reg;
        wr_en           = '0;
        wr_row          = '0;
        wr_data         = '0;
        rd_en           = 1'b0;
        rd_row          = mem_pos[ROW_W+1:2];

        if (in_acc)
        begin
            res_valid_next = 1'b0;
            if (item.op == OP_DRAIN)
            begin
                if (pending_reg)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = STATUS_BUNDLE;
                    res_last_next   = drain_last;
                    res_mem_next    = 1'b0;
                    res_byte_next   = '0;
                    if (didx_reg == IW'(0))
                    begin
                        res_byte_next = prefix[7:0];
                    end
                    else if (didx_reg == IW'(1))
                    begin
                        res_byte_next = prefix[15:8];
                    end
                    else if (mem_pos < wc_ext)
                    begin
                        rd_en         = 1'b1;
                        res_mem_next  = 1'b1;
                        res_lane_next = mem_pos[LANE_BITS-1:0];
                    end
                    if (drain_last)
                    begin
                        pending_next = 1'b0;
                        didx_next    = '0;
                        wc_next      = '0;
                    end
                    else
                    begin
                        didx_next = didx_reg + IW'(1);
                    end
                end
            end
            else if (pending_reg)
            begin
                res_valid_next  = 1'b1;
                res_byte_next   = '0;
                res_last_next   = 1'b0;
                res_status_next = STATUS_BUSY;
                res_mem_next    = 1'b0;
            end
            else
            begin
                if (stored)
                begin
                    wc_next = wc_reg + WCW'(1);
                    wr_en[wc_ext[LANE_BITS-1:0]]   = 1'b1;
                    wr_row[wc_ext[LANE_BITS-1:0]]  = wc_ext[ROW_W+1:2];
                    wr_data[wc_ext[LANE_BITS-1:0]] = zero_fill ? 8'h00 : item.in_byte;
                end
                else
                begin
                    res_valid_next  = 1'b1;
                    res_byte_next   = '0;
                    res_last_next   = 1'b0;
                    res_status_next = STATUS_OVERFLOW;
                    res_mem_next    = 1'b0;
                end

                case (phase_reg)
                    PH_TYPE:
                    begin
                        rtype_next = item.in_byte;
                        phase_next = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        rem_next   = {1'b0, item.in_byte} + 9'd1;
                        acc_next   = '0;
                        start_next = wc_ext + IW'(1);
                        phase_next = PH_DATA;
                    end
                    PH_DATA:
                    begin
                        acc_next = acc_shift;
                        rem_next = rem_dec;
                        if (rem_dec == 9'd0)
                        begin
                            phase_next = PH_TYPE;
                            if (rtype_reg == REC_ADDR)
                            begin
                                // rebased value replaces the field tail, this byte included
                                for (int l = 0; l < LANES; l++)
                                begin
                                    wr_en[l]   = wb_ok[l];
                                    wr_row[l]  = wb_pos[l][ROW_W+1:2];
                                    wr_data[l] = wb_byte[l];
                                end
                            end
                            else if (rtype_reg == REC_END)
                            begin
                                pending_next = 1'b1;
                                didx_next    = '0;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_TYPE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TYPE;
            rtype_reg     <= '0;
            rem_reg       <= '0;
            acc_reg       <= '0;
            start_reg     <= '0;
            wc_reg        <= '0;
            pending_reg   <= 1'b0;
            didx_reg      <= '0;
            base_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            rtype_reg     <= rtype_next;
            rem_reg       <= rem_next;
            acc_reg       <= acc_next;
            start_reg     <= start_next;
            wc_reg        <= wc_next;
            pending_reg   <= pending_next;
            didx_reg      <= didx_next;
            res_valid_reg <= res_valid_next;
            if (base_we)
            begin
                base_reg <= base_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_byte_reg   <= res_byte_next;
        res_last_reg   <= res_last_next;
        res_status_reg <= res_status_next;
        res_mem_reg    <= res_mem_next;
        res_lane_reg   <= res_lane_next;
    end

    tlvbf_lane_store #(
        .DEPTH (BUNDLE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_row  (wr_row),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_row  (rd_row),
        .rd_data (rd_data)
    );

    assign item.ready      = in_ready;
    assign result.valid    = res_valid_reg;
    assign result.out_byte = res_mem_reg ? rd_data[res_lane_reg] : res_byte_reg;
    assign result.last     = res_last_reg;
    assign result.status   = res_status_reg;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_wc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wc_reg <= WCW'(BUNDLE_DEPTH))
        else $error("write count beyond bundle depth");

    a_didx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> ({1'b0, didx_reg} <= ({1'b0, wc_ext} + IW1'(1))))
        else $error("drain index past end of bundle");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (item.op == OP_BYTE) && pending_reg
        |=> result.valid && (result.status == STATUS_BUSY))
        else $error("stream byte during drain not refused");

    a_last_bundle: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.last |-> (result.status == STATUS_BUNDLE))
        else $error("last on a non-bundle word");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the TLV bundle framer. A bundle-tracking model
// follows every accepted word (record parse, rebase write-back, overflow,
// busy refusal, drain with length prefix) and queues the bytes the block
// should emit; a monitor matches each emitted word against the queue.
// Directed records come first, then random bundles under random base values
// and random gaps on both sides, then a store overflow with a long stall.
// ----------------------------------------------------------------------------
module tb_top;
    import tlvbf_pkg::*;

    localparam int DEPTH = DEFAULT_BUNDLE_DEPTH;

    // parser position inside the current record
    typedef enum logic [1:0] {PH_TYPE, PH_LEN, PH_DATA} parse_ph_t;

    typedef struct packed {
        logic [7:0]          data;
        logic                last;
        logic [STATUS_W-1:0] status;
    } out_word_t;

    logic        clk;
    logic        rst_n;
    logic        base_we;
    logic [31:0] base_wdata;

    tlvbf_in_if  item_if();
    tlvbf_out_if result_if();

    tlv_bundle_framer_with_rebase dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_if),
        .result     (result_if),
        .base_we    (base_we),
        .base_wdata (base_wdata)
    );

    // ------------------------------------------------------------------
    // Bundle model state, mirrors the block at word acceptance
    // ------------------------------------------------------------------
    parse_ph_t   frm_phase;
    logic [7:0]  frm_type;
    logic [8:0]  frm_left;
    logic [31:0] frm_acc;
    logic [11:0] frm_fstart;
    logic [7:0]  frm_store [DEPTH];
    logic [11:0] frm_count;
    logic        frm_draining;
    logic [11:0] frm_dindex;
    logic [31:0] frm_base;

    out_word_t   emitted_q[$];   // bytes still owed by the block, oldest first
    int          err_cnt;
    int          live_items;     // words that the block did not just ignore

    bit          tx_idle;        // random gaps on the item side
    bit          rx_idle;        // random stalls on the result side
    int          rx_hold;        // one-off long stall, picked up by the sink

    // Work out what one accepted word does to the bundle and what it emits.
    function automatic void advance_framer(input logic op, input logic [7:0] b);
        logic [31:0] total;
        logic [31:0] span;
        logic [31:0] sum;
        logic [31:0] pos;
        logic        dropped;
        out_word_t   w;
        int          k;
        dropped = 1'b0;
        w       = '0;
        if (op == OP_DRAIN) begin
            // tick with no closed bundle does nothing
            if (!frm_draining)
                return;
            live_items++;
            total = 32'(frm_count) + 32'd2;
            if (frm_dindex == 12'd0)
                w.data = frm_count[7:0];
            else if (frm_dindex == 12'd1)
                w.data = {4'h0, frm_count[11:8]};
            else
                w.data = frm_store[frm_dindex - 12'd2];
            w.last   = (32'(frm_dindex) + 32'd1 >= total);
            w.status = STATUS_BUNDLE;
            emitted_q.push_back(w);
            if (w.last) begin
                frm_draining = 1'b0;
                frm_dindex   = '0;
                frm_count    = '0;
            end
            else
                frm_dindex++;
            return;
        end
        live_items++;
        if (frm_draining) begin
            w.status = STATUS_BUSY;
            emitted_q.push_back(w);
            return;
        end
        // store the byte, or drop it once the store is full (still parsed)
        if (32'(frm_count) < DEPTH) begin
            frm_store[frm_count] = b;
            frm_count++;
        end
        else
            dropped = 1'b1;
        case (frm_phase)
            PH_TYPE:
            begin
                frm_type  = b;
                frm_phase = PH_LEN;
            end
            PH_LEN:
            begin
                frm_left   = {1'b0, b} + 9'd1;
                frm_acc    = '0;
                frm_fstart = frm_count + 12'(dropped);
                frm_phase  = PH_DATA;
            end
            default:
            begin
                frm_acc = {frm_acc[23:0], b};
                if (frm_left > 9'd0)
                    frm_left--;
                if (frm_left == 9'd0) begin
                    frm_phase = PH_TYPE;
                    if (frm_type == REC_ADDR) begin
                        // rebased value goes back big-endian over the tail of the
                        // field; anything further up is cleared, dropped bytes
                        // are left alone
                        span = 32'(frm_count) + 32'(dropped) - 32'(frm_fstart);
                        sum  = frm_acc + frm_base;
                        for (k = 0; k < span; k++) begin
                            pos = 32'(frm_fstart) + span - 32'd1 - 32'(k);
                            if (pos < 32'(frm_count) && pos < DEPTH)
                                frm_store[pos] = (k < 4) ? 8'(sum >> (8 * k)) : 8'h00;
                        end
                    end
                    else if (frm_type == REC_END) begin
                        frm_draining = 1'b1;
                        frm_dindex   = '0;
                    end
                end
            end
        endcase
        if (dropped) begin
            w.status = STATUS_OVERFLOW;
            emitted_q.push_back(w);
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // time limit: several times the slowest legal run, hold-off included
    initial
    begin
        #8_000_000;
        $display("tlv_bundle_framer_with_rebase test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result monitor: every emitted word is matched against the queue
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && result_if.valid && result_if.ready) begin
            if (emitted_q.size() == 0) begin
                if (err_cnt < 10)
                    $display("%0t: unexpected word byte=%h last=%b status=%0d", $realtime,
                             result_if.out_byte, result_if.last, result_if.status);
                err_cnt++;
            end
            else begin
                want = emitted_q.pop_front();
                if (result_if.out_byte !== want.data || result_if.last !== want.last ||
                    result_if.status !== want.status) begin
                    if (err_cnt < 10)
                        $display("%0t: mismatch exp byte=%h last=%b status=%0d, got byte=%h last=%b status=%0d",
                                 $realtime, want.data, want.last, want.status,
                                 result_if.out_byte, result_if.last, result_if.status);
                    err_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: random stall per word, plus the odd long hold-off
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int stall;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            stall = rx_idle ? $urandom_range(0, 10) : 0;
            if (rx_hold > 0) begin
                stall   = rx_hold;
                rx_hold = 0;
            end
            if (stall > 0) begin
                result_if.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_if.ready = 1'b1;
            do @(posedge clk); while (!result_if.valid);
        end
    end

    // ------------------------------------------------------------------
    // Item side helpers; all entered and left at a falling edge
    // ------------------------------------------------------------------
    // Offer one word, hold it until taken, then update the model.
    task automatic send_word(input logic op, input logic [7:0] b);
        int gap;
        gap = tx_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            item_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_if.valid   = 1'b1;
        item_if.op      = op;
        item_if.in_byte = b;
        do @(posedge clk); while (!item_if.ready);
        advance_framer(op, b);
        @(negedge clk);
    endtask

    // type, length, then length+1 random data bytes
    task automatic send_record(input logic [7:0] rtype, input logic [7:0] rlen);
        send_word(OP_BYTE, rtype);
        send_word(OP_BYTE, rlen);
        repeat (int'(rlen) + 1) send_word(OP_BYTE, 8'($urandom()));
    endtask

    // Tick the closed bundle out; with noise, stray bytes are refused as busy.
    task automatic drain_bundle(input bit noise);
        while (frm_draining) begin
            if (noise && $urandom_range(0, 11) == 0)
                send_word(OP_BYTE, 8'($urandom()));
            else
                send_word(OP_DRAIN, 8'($urandom()));
        end
    endtask

    // Quiet the item side and let every owed word come out.
    task automatic wait_drained();
        item_if.valid = 1'b0;
        while (emitted_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Only called once the block is idle.
    task automatic write_base(input logic [31:0] value);
        base_we    = 1'b1;
        base_wdata = value;
        @(negedge clk);
        base_we    = 1'b0;
        frm_base   = value;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Idle tick, long address field that wraps to zero under an all-ones
    // base, close, busy byte mid-drain, then the drain.
    task automatic test_directed();
        logic [7:0] seq [11];
        int i;
        seq = '{REC_ADDR, 8'h05, 8'hff, 8'h80, 8'h00, 8'h00, 8'h00, 8'h01,
                REC_END, 8'h00, 8'h00};
        wait_drained();
        write_base(32'hffff_ffff);
        send_word(OP_DRAIN, 8'hff);
        for (i = 0; i < 11; i++)
            send_word(OP_BYTE, seq[i]);
        send_word(OP_DRAIN, 8'h00);
        send_word(OP_BYTE, 8'hff);
        drain_bundle(1'b0);
    endtask

    // Mostly well-formed bundles with random content; some stray ticks and
    // stray bytes that knock the parser out of step.
    task automatic test_random_bundles();
        int         start;
        int         n_rec;
        int         pick;
        logic [7:0] rtype;
        logic [7:0] rlen;
        start = live_items;
        while (live_items - start < 1550) begin
            if ($urandom_range(0, 3) == 0) begin
                wait_drained();
                pick = $urandom_range(0, 3);
                write_base(pick == 0 ? 32'h0 : pick == 1 ? 32'hffff_ffff : $urandom());
            end
            tx_idle = ($urandom_range(0, 4) != 0);
            rx_idle = ($urandom_range(0, 4) != 0);
            n_rec   = $urandom_range(1, 5);
            repeat (n_rec) begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    send_word(OP_DRAIN, 8'($urandom()));
                else if (pick == 1)
                    repeat ($urandom_range(1, 3)) send_word(OP_BYTE, 8'($urandom()));
                rtype = $urandom_range(0, 1) ? REC_ADDR : 8'($urandom());
                if (rtype == REC_END)
                    rtype = 8'h00;
                pick = $urandom_range(0, 19);
                rlen = (pick < 16) ? 8'($urandom_range(0, 7)) :
                       (pick < 19) ? 8'($urandom_range(0, 31)) : 8'($urandom());
                send_record(rtype, rlen);
            end
            send_record(REC_END, 8'($urandom_range(0, 3)));
            // a run of 0x17 always lands on a type byte sooner or later
            while (!frm_draining)
                send_word(OP_BYTE, REC_END);
            drain_bundle(1'b1);
        end
    endtask

    // Fill past capacity so the record crossing the limit is an address
    // record, keep going with fully dropped records, close, then drain with
    // the sink held off long enough to back the block up.
    task automatic test_overflow();
        int         extra;
        logic [7:0] rtype;
        logic [7:0] rlen;
        wait_drained();
        write_base($urandom());
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        extra   = 0;
        while (extra < 3) begin
            rlen = 8'($urandom());
            if (32'(frm_count) < DEPTH && 32'(frm_count) + 32'(rlen) + 32'd3 > DEPTH)
                rtype = REC_ADDR;
            else begin
                rtype = $urandom_range(0, 2) == 0 ? REC_ADDR : 8'($urandom());
                if (rtype == REC_END)
                    rtype = 8'hff;
            end
            if (32'(frm_count) == DEPTH)
                extra++;
            send_record(rtype, rlen);
        end
        send_record(REC_END, 8'h00);
        while (!frm_draining)
            send_word(OP_BYTE, REC_END);
        tx_idle = 1'b1;
        rx_hold = 400;
        drain_bundle(1'b1);
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial
    begin
        int settle;
        rst_n             = 1'b0;
        base_we           = 1'b0;
        base_wdata        = '0;
        item_if.valid     = 1'b0;
        item_if.op        = OP_BYTE;
        item_if.in_byte   = '0;
        result_if.ready   = 1'b0;
        tx_idle           = 1'b1;
        rx_idle           = 1'b1;
        rx_hold           = 0;
        err_cnt           = 0;
        live_items        = 0;
        frm_phase         = PH_TYPE;
        frm_type          = '0;
        frm_left          = '0;
        frm_acc           = '0;
        frm_fstart        = '0;
        frm_count         = '0;
        frm_draining      = 1'b0;
        frm_dindex        = '0;
        frm_base          = '0;
        foreach (frm_store[i])
            frm_store[i] = '0;

        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random_bundles();
        test_overflow();

        // let the last words out, bounded, then a short tail
        item_if.valid = 1'b0;
        settle = 0;
        while (emitted_q.size() != 0 && settle < 50000) begin
            @(negedge clk);
            settle++;
        end
        repeat (8) @(negedge clk);
        if (emitted_q.size() != 0) begin
            $display("%0d expected words never arrived", emitted_q.size());
            err_cnt += emitted_q.size();
        end

        if (err_cnt == 0)
            $display("tlv_bundle_framer_with_rebase test passed");
        else
            $display("tlv_bundle_framer_with_rebase test failed");
        $finish;
    end

endmodule

/* sim.f */
src/tlvbf_pkg.sv
src/tlvbf_in_if.sv
src/tlvbf_out_if.sv
src/tlvbf_lane_store.sv
src/tlv_bundle_framer_with_rebase.sv
tb/tb_top.sv
